@@ src/rgb2yuv_pkg.sv @@
// Shared types and constants for the RGB to YUV 4:2:0 stream converter.
// No dependencies.
package rgb2yuv_pkg;

  localparam int MAX_LINE_PIXELS = 4096;
  localparam int MAX_FRAME_LINES = 4096;
  localparam int MAX_PAIRS       = MAX_LINE_PIXELS / 2;

  localparam int PAIRS_W = 12;
  localparam int LINES_W = 13;
  localparam int COL_W   = 12;
  localparam int ROW_W   = 12;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [PAIRS_W-1:0] PAIRS_RESET = PAIRS_W'(320);
  localparam logic [LINES_W-1:0] LINES_RESET = LINES_W'(480);

  // register index, taken from paddr[2]
  localparam logic REG_PAIRS = 1'b0;
  localparam logic REG_LINES = 1'b1;

  typedef struct packed {
    logic chroma;
    logic line_end;
    logic frame_end;
  } pos_flags_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    logic [7:0] cr;
    logic [7:0] cb;
    logic [7:0] luma;
  } yuv_t;

endpackage

@@ src/rgb2yuv_cfg.sv @@
// APB-style register file: pairs_per_line and lines_per_frame.
// Depends on rgb2yuv_pkg.
module rgb2yuv_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rgb2yuv_pkg::ADDR_W-1:0]   paddr,
  input  logic [rgb2yuv_pkg::DATA_W-1:0]   pwdata,
  output logic [rgb2yuv_pkg::DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [rgb2yuv_pkg::PAIRS_W-1:0]  pairs_per_line,
  output logic [rgb2yuv_pkg::LINES_W-1:0]  lines_per_frame
);

  logic [rgb2yuv_pkg::PAIRS_W-1:0] pairs_r;
  logic [rgb2yuv_pkg::LINES_W-1:0] lines_r;
  logic                            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pairs_r <= rgb2yuv_pkg::PAIRS_RESET;
      lines_r <= rgb2yuv_pkg::LINES_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        rgb2yuv_pkg::REG_PAIRS: pairs_r <= pwdata[rgb2yuv_pkg::PAIRS_W-1:0];
        rgb2yuv_pkg::REG_LINES: lines_r <= pwdata[rgb2yuv_pkg::LINES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rgb2yuv_pkg::REG_PAIRS:
        prdata = {{(rgb2yuv_pkg::DATA_W-rgb2yuv_pkg::PAIRS_W){1'b0}}, pairs_r};
      rgb2yuv_pkg::REG_LINES:
        prdata = {{(rgb2yuv_pkg::DATA_W-rgb2yuv_pkg::LINES_W){1'b0}}, lines_r};
      default: prdata = '0;
    endcase
  end

  assign pairs_per_line  = pairs_r;
  assign lines_per_frame = lines_r;

endmodule

@@ src/rgb2yuv_raster.sv @@
// Column and line counters; flags chroma sites and line/frame ends.
// Depends on rgb2yuv_pkg.
module rgb2yuv_raster (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             advance,
  input  logic [rgb2yuv_pkg::PAIRS_W-1:0]  pairs_per_line,
  input  logic [rgb2yuv_pkg::LINES_W-1:0]  lines_per_frame,
  output rgb2yuv_pkg::pos_flags_t          flags
);

  localparam int WID_W = rgb2yuv_pkg::COL_W + 1;
  localparam int HGT_W = rgb2yuv_pkg::ROW_W + 1;

  logic [rgb2yuv_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [rgb2yuv_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [rgb2yuv_pkg::PAIRS_W-1:0] pairs_cl;
  logic [rgb2yuv_pkg::LINES_W-1:0] lines_cl;
  logic [WID_W-1:0]                width;
  logic                            lend, fend;

  always_comb begin
    pairs_cl = pairs_per_line;
    if (pairs_per_line == '0)
      pairs_cl = rgb2yuv_pkg::PAIRS_W'(1);
    else if (pairs_per_line > rgb2yuv_pkg::PAIRS_W'(rgb2yuv_pkg::MAX_PAIRS))
      pairs_cl = rgb2yuv_pkg::PAIRS_W'(rgb2yuv_pkg::MAX_PAIRS);
    lines_cl = lines_per_frame;
    if (lines_per_frame == '0)
      lines_cl = rgb2yuv_pkg::LINES_W'(1);
    else if (lines_per_frame > rgb2yuv_pkg::LINES_W'(rgb2yuv_pkg::MAX_FRAME_LINES))
      lines_cl = rgb2yuv_pkg::LINES_W'(rgb2yuv_pkg::MAX_FRAME_LINES);
  end

  assign width = WID_W'({pairs_cl, 1'b0});
  assign lend  = (WID_W'(col_r) + WID_W'(1)) >= width;
  assign fend  = lend && ((HGT_W'(row_r) + HGT_W'(1)) >= HGT_W'(lines_cl));

  always_comb begin
    col_nxt = col_r + rgb2yuv_pkg::COL_W'(1);
    row_nxt = row_r;
    if (lend) begin
      col_nxt = '0;
      row_nxt = fend ? '0 : row_r + rgb2yuv_pkg::ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign flags.chroma    = ~row_r[0] & ~col_r[0];
  assign flags.line_end  = lend;
  assign flags.frame_end = fend;

endmodule

@@ src/rgb2yuv_csc.sv @@
// BT.601 integer color conversion, one pixel, combinational.
// Depends on rgb2yuv_pkg.
module rgb2yuv_csc (
  input  rgb2yuv_pkg::rgb_t pix,
  input  logic              chroma,
  output rgb2yuv_pkg::yuv_t yuv
);

  logic signed [17:0] r_s, g_s, b_s;
  logic signed [17:0] y_sum, u_sum, v_sum;

  assign r_s = signed'({10'b0, pix.red});
  assign g_s = signed'({10'b0, pix.green});
  assign b_s = signed'({10'b0, pix.blue});

  assign y_sum = 18'sd66 * r_s + 18'sd129 * g_s + 18'sd25 * b_s;
  assign u_sum = -18'sd38 * r_s - 18'sd74 * g_s + 18'sd112 * b_s;
  assign v_sum = 18'sd112 * r_s - 18'sd94 * g_s - 18'sd18 * b_s;

  // floor(sum/256) mod 256 is bits [15:8] in two's complement
  assign yuv.luma = y_sum[15:8] + 8'd16;
  assign yuv.cb   = chroma ? u_sum[15:8] + 8'd128 : 8'd0;
  assign yuv.cr   = chroma ? v_sum[15:8] + 8'd128 : 8'd0;

endmodule

@@ src/rgb_to_yuv420_stream.sv @@
// Top level of the RGB888 to YUV 4:2:0 stream converter.
// Depends on rgb2yuv_pkg, rgb2yuv_cfg, rgb2yuv_raster, rgb2yuv_csc.
// One pixel per transfer in raster order; one result per pixel, through an
// input register, then a result register; one pixel per clock sustained while
// out_tready is high. Luma on every pixel; cb/cr on the even column of even
// lines with tuser[0] set, else zero. tlast marks the last pixel of a line,
// tuser[1] the last pixel of a frame. Line width is programmed in pixel pairs.
module rgb_to_yuv420_stream (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,   // red, green, blue
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // luma, cb, cr
  output logic                           out_tlast,  // line_end
  output logic [1:0]                     out_tuser,  // chroma_valid, frame_end
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [rgb2yuv_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [rgb2yuv_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [rgb2yuv_pkg::DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  logic [rgb2yuv_pkg::PAIRS_W-1:0] pairs_per_line;
  logic [rgb2yuv_pkg::LINES_W-1:0] lines_per_frame;
  rgb2yuv_pkg::pos_flags_t         pos_flags;
  rgb2yuv_pkg::pos_flags_t         s1_flags_r;
  rgb2yuv_pkg::rgb_t               s1_pix_r;
  rgb2yuv_pkg::yuv_t               yuv;
  rgb2yuv_pkg::yuv_t               out_yuv_r;
  logic                            s1_v_r, s1_v_nxt;
  logic                            out_v_r, out_v_nxt;
  logic                            out_chroma_r, out_lend_r, out_fend_r;
  logic                            in_xfer, s2_ready, s1_move;

  rgb2yuv_cfg u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (cfg_psel),
    .penable         (cfg_penable),
    .pwrite          (cfg_pwrite),
    .paddr           (cfg_paddr),
    .pwdata          (cfg_pwdata),
    .prdata          (cfg_prdata),
    .pready          (cfg_pready),
    .pairs_per_line  (pairs_per_line),
    .lines_per_frame (lines_per_frame)
  );

  rgb2yuv_raster u_raster (
    .clk             (clk),
    .rst_n           (rst_n),
    .advance         (in_xfer),
    .pairs_per_line  (pairs_per_line),
    .lines_per_frame (lines_per_frame),
    .flags           (pos_flags)
  );

  rgb2yuv_csc u_csc (
    .pix    (s1_pix_r),
    .chroma (s1_flags_r.chroma),
    .yuv    (yuv)
  );

  assign s2_ready  = ~out_v_r | out_tready;
  assign s1_move   = s1_v_r & s2_ready;
  assign in_tready = ~s1_v_r | s2_ready;
  assign in_xfer   = in_tvalid & in_tready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_xfer)
      s1_v_nxt = 1'b1;
    else if (s1_move)
      s1_v_nxt = 1'b0;
    out_v_nxt = out_v_r;
    if (s1_move)
      out_v_nxt = 1'b1;
    else if (out_tready)
      out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pix_r   <= in_tdata;
      s1_flags_r <= pos_flags;
    end
    if (s1_move) begin
      out_yuv_r    <= yuv;
      out_chroma_r <= s1_flags_r.chroma;
      out_lend_r   <= s1_flags_r.line_end;
      out_fend_r   <= s1_flags_r.frame_end;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_yuv_r;
  assign out_tlast  = out_lend_r;
  assign out_tuser  = {out_fend_r, out_chroma_r};

  a_fend_has_lend: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser[1] || out_tlast))
    else $error("frame end without line end");

  a_no_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[23:8] == 16'd0))
    else $error("chroma samples set off a chroma site");

  a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_tready) |-> !in_tready)
    else $error("input taken while both stages are held");

  a_stage_feeds_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_v_r)
    else $error("stage one moved without a result");

endmodule
